// ----- src/compton_pair_window_check_unit_macros.svh -----
// Assertion macros for the Compton pair window check unit.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef COMPTON_PAIR_WINDOW_CHECK_UNIT_MACROS_SVH
`define COMPTON_PAIR_WINDOW_CHECK_UNIT_MACROS_SVH

// Consequent must hold in the same cycle
`define CPWC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpwc assertion failed");

// Consequent must hold in the next cycle
`define CPWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpwc assertion failed");

`endif

// ----- src/cpwc_pkg.sv -----
// Shared types and constants for the Compton pair window check unit.
// No dependencies.
package cpwc_pkg;

  localparam int ENERGY_W  = 18;
  localparam int T_W       = 19;
  localparam int E_W       = 20;   // widened total / quotient width
  localparam int WORD_W    = 17;
  localparam int RES_W     = 13;
  localparam int DEN_W     = 38;
  localparam int NUM_W     = 47;
  localparam int DIV_STEPS = 20;

  localparam logic [RES_W-1:0] RES_RESET = 13'd151;
  // 8 * 511 * 2^15 = 511 * 2^18
  localparam logic [DEN_W-1:0] REST_DEN   = 38'd133955584;
  localparam int               REST_MULT  = 511;
  localparam int               REST_SHIFT = 18;

  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_WR_FWD = 2'd1,
    CMD_WR_BWD = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [E_W-1:0]   low;   // numerator bits still to shift in
    logic [E_W-1:0]   quo;
  } div_lane_t;

  typedef struct packed {
    logic                valid;
    logic                check;
    logic [T_W-1:0]      t;
    logic [ENERGY_W-1:0] e1;
    logic [ENERGY_W-1:0] e2;
  } side_t;

  typedef struct packed {
    side_t     side;
    div_lane_t lane_u;
    div_lane_t lane_l;
  } stage_t;

endpackage

// ----- src/cpwc_front.sv -----
// Front end: bound tables, total, widened totals, divider operands.
// Uses cpwc_pkg. Three register stages.
module cpwc_front #(
  parameter int BINS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [1:0]                    in_command,
  input  logic [5:0]                    in_angle_bin,
  input  logic [cpwc_pkg::ENERGY_W-1:0] in_energy_first,
  input  logic [cpwc_pkg::ENERGY_W-1:0] in_energy_second,
  input  logic [cpwc_pkg::WORD_W-1:0]   in_table_word,
  input  logic [cpwc_pkg::RES_W-1:0]    resolution,
  output cpwc_pkg::stage_t              stage_out
);

  localparam int IDX_W = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int EXT_W = (IDX_W > 6) ? IDX_W : 6;

  logic [cpwc_pkg::WORD_W-1:0] fwd_mem [BINS];
  logic [cpwc_pkg::WORD_W-1:0] bwd_mem [BINS];

  logic             acc;
  logic             in_rng;
  logic [EXT_W-1:0] bin_ext;
  logic [IDX_W-1:0] idx;
  logic             is_check, wr_f, wr_b;

  assign acc     = in_valid && en;
  assign bin_ext = EXT_W'(in_angle_bin);
  assign idx     = bin_ext[IDX_W-1:0];
  assign in_rng  = (32'(in_angle_bin) < BINS);

  // command decode
  always_comb begin
    is_check = 1'b0;
    wr_f     = 1'b0;
    wr_b     = 1'b0;
    case (cpwc_pkg::cmd_t'(in_command))
      cpwc_pkg::CMD_CHECK:  is_check = in_rng;
      cpwc_pkg::CMD_WR_FWD: wr_f     = in_rng;
      cpwc_pkg::CMD_WR_BWD: wr_b     = in_rng;
      default: begin
      end
    endcase
  end

  // table memories, registered read
  logic [cpwc_pkg::WORD_W-1:0] kf1_r, kb1_r;

  always_ff @(posedge clk) begin
    if (acc && wr_f) begin
      fwd_mem[idx] <= in_table_word;
    end
    if (acc && wr_b) begin
      bwd_mem[idx] <= in_table_word;
    end
    if (acc) begin
      kf1_r <= fwd_mem[idx];
      kb1_r <= bwd_mem[idx];
    end
  end

  // stage 1: total
  logic                          v1_r, chk1_r;
  logic [cpwc_pkg::T_W-1:0]      t1_r;
  logic [cpwc_pkg::ENERGY_W-1:0] a1_r, b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      chk1_r <= is_check;
      t1_r   <= cpwc_pkg::T_W'(in_energy_first) + cpwc_pkg::T_W'(in_energy_second);
      a1_r   <= in_energy_first;
      b1_r   <= in_energy_second;
    end
  end

  // stage 2: widened totals
  logic [16:0] fac_u, fac_l;
  logic [35:0] prod_u, prod_l;

  assign fac_u  = 17'h10000 + 17'({resolution, 1'b0});
  assign fac_l  = 17'h10000 - 17'({resolution, 1'b0});
  assign prod_u = 36'(t1_r) * 36'(fac_u);
  assign prod_l = 36'(t1_r) * 36'(fac_l);

  logic                          v2_r, chk2_r;
  logic [cpwc_pkg::T_W-1:0]      t2_r;
  logic [cpwc_pkg::ENERGY_W-1:0] a2_r, b2_r;
  logic [cpwc_pkg::WORD_W-1:0]   kf2_r, kb2_r;
  logic [cpwc_pkg::E_W-1:0]      tu2_r, tl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chk2_r <= chk1_r;
      t2_r   <= t1_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      kf2_r  <= kf1_r;
      kb2_r  <= kb1_r;
      tu2_r  <= prod_u[35:16];
      tl2_r  <= prod_l[35:16];
    end
  end

  // stage 3: numerator E*D and denominator D + E*k
  logic [cpwc_pkg::DEN_W-1:0] ek_u, ek_l, den_u, den_l;
  logic [28:0]                m_u, m_l;
  logic [cpwc_pkg::NUM_W-1:0] num_u, num_l;

  assign ek_u  = 38'(tu2_r) * 38'(kf2_r);
  assign ek_l  = 38'(tl2_r) * 38'(kb2_r);
  assign den_u = cpwc_pkg::REST_DEN + ek_u;
  assign den_l = cpwc_pkg::REST_DEN + ek_l;
  assign m_u   = 29'(tu2_r) * 29'(cpwc_pkg::REST_MULT);
  assign m_l   = 29'(tl2_r) * 29'(cpwc_pkg::REST_MULT);
  assign num_u = {m_u, {cpwc_pkg::REST_SHIFT{1'b0}}};
  assign num_l = {m_l, {cpwc_pkg::REST_SHIFT{1'b0}}};

  cpwc_pkg::stage_t stage_nxt, stage_r;

  always_comb begin
    stage_nxt.side.valid  = v2_r;
    stage_nxt.side.check  = chk2_r;
    stage_nxt.side.t      = t2_r;
    stage_nxt.side.e1     = a2_r;
    stage_nxt.side.e2     = b2_r;
    // quotient fits in E_W bits, so the high part starts below the divisor
    stage_nxt.lane_u.rem  = 38'(num_u[cpwc_pkg::NUM_W-1:cpwc_pkg::E_W]);
    stage_nxt.lane_u.den  = den_u;
    stage_nxt.lane_u.low  = num_u[cpwc_pkg::E_W-1:0];
    stage_nxt.lane_u.quo  = '0;
    stage_nxt.lane_l.rem  = 38'(num_l[cpwc_pkg::NUM_W-1:cpwc_pkg::E_W]);
    stage_nxt.lane_l.den  = den_l;
    stage_nxt.lane_l.low  = num_l[cpwc_pkg::E_W-1:0];
    stage_nxt.lane_l.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.side.valid <= 1'b0;
    end else if (en) begin
      stage_r.side.valid <= stage_nxt.side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r.side.check <= stage_nxt.side.check;
      stage_r.side.t     <= stage_nxt.side.t;
      stage_r.side.e1    <= stage_nxt.side.e1;
      stage_r.side.e2    <= stage_nxt.side.e2;
      stage_r.lane_u     <= stage_nxt.lane_u;
      stage_r.lane_l     <= stage_nxt.lane_l;
    end
  end

  assign stage_out = stage_r;

endmodule

// ----- src/cpwc_div_stage.sv -----
// One restoring division step for both scatter-bound dividers.
// Uses cpwc_pkg. One quotient bit per lane per stage.
module cpwc_div_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  cpwc_pkg::stage_t stage_in,
  output cpwc_pkg::stage_t stage_out
);

  function automatic cpwc_pkg::div_lane_t div_step(input cpwc_pkg::div_lane_t l);
    cpwc_pkg::div_lane_t r;
    logic [cpwc_pkg::DEN_W:0] trial;
    logic                     ge;
    trial = {l.rem, l.low[cpwc_pkg::E_W-1]};
    ge    = (trial >= {1'b0, l.den});
    r.den = l.den;
    r.rem = ge ? cpwc_pkg::DEN_W'(trial - {1'b0, l.den}) : trial[cpwc_pkg::DEN_W-1:0];
    r.low = {l.low[cpwc_pkg::E_W-2:0], 1'b0};
    r.quo = {l.quo[cpwc_pkg::E_W-2:0], ge};
    return r;
  endfunction

  cpwc_pkg::stage_t stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.side.valid <= 1'b0;
    end else if (en) begin
      stage_r.side.valid <= stage_in.side.valid;
    end
  end

  // step both lanes, carry side data along
  always_ff @(posedge clk) begin
    if (en) begin
      stage_r.side.check <= stage_in.side.check;
      stage_r.side.t     <= stage_in.side.t;
      stage_r.side.e1    <= stage_in.side.e1;
      stage_r.side.e2    <= stage_in.side.e2;
      stage_r.lane_u     <= div_step(stage_in.lane_u);
      stage_r.lane_l     <= div_step(stage_in.lane_l);
    end
  end

  assign stage_out = stage_r;

endmodule

// ----- src/compton_pair_window_check_unit.sv -----
// Top level of the Compton pair window check unit.
// Uses cpwc_pkg, cpwc_front, cpwc_div_stage and the macros header.
//
// Takes one transaction per cycle while the output is not stalled and
// returns one result per transaction, through 3 front stages, 20 divider
// stages (two 20-step restoring dividers for the scatter bounds) and one
// output register. A stall on the output freezes the whole pipeline.
// Bound tables must be written before a check reads them. The resolution
// register may only be written while no transaction is in flight.
module compton_pair_window_check_unit #(
  parameter int BINS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [5:0]                    in_angle_bin,
  input  logic [cpwc_pkg::ENERGY_W-1:0] in_energy_first,
  input  logic [cpwc_pkg::ENERGY_W-1:0] in_energy_second,
  input  logic [cpwc_pkg::WORD_W-1:0]   in_table_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_candidate,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cpwc_pkg::RES_W-1:0]    cfg_resolution
);

  `include "compton_pair_window_check_unit_macros.svh"

  logic advance;
  logic out_valid_r, out_is_candidate_r;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;

  // configuration register
  logic [cpwc_pkg::RES_W-1:0] res_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= cpwc_pkg::RES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      res_r <= cfg_resolution;
    end
  end

  // front end
  cpwc_pkg::stage_t chain [cpwc_pkg::DIV_STEPS+1];

  cpwc_front #(.BINS(BINS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (advance),
    .in_valid         (in_valid),
    .in_command       (in_command),
    .in_angle_bin     (in_angle_bin),
    .in_energy_first  (in_energy_first),
    .in_energy_second (in_energy_second),
    .in_table_word    (in_table_word),
    .resolution       (res_r),
    .stage_out        (chain[0])
  );

  // divider chain
  for (genvar g = 0; g < cpwc_pkg::DIV_STEPS; g++) begin : g_div
    cpwc_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .stage_in  (chain[g]),
      .stage_out (chain[g+1])
    );
  end

  // window compare
  cpwc_pkg::stage_t  last;
  logic [19:0]       su, sl;
  logic [19:0]       a_ext, b_ext;
  logic signed [21:0] lo2, hi2, a_s, b_s;
  logic              a_in1, b_in1, a_in2, b_in2, fit;

  assign last  = chain[cpwc_pkg::DIV_STEPS];
  assign su    = last.lane_u.quo;
  assign sl    = last.lane_l.quo;
  assign a_ext = 20'(last.side.e1);
  assign b_ext = 20'(last.side.e2);
  assign lo2   = $signed(22'(last.side.t)) - $signed(22'(su));
  assign hi2   = $signed(22'(last.side.t)) - $signed(22'(sl));
  assign a_s   = $signed(22'(last.side.e1));
  assign b_s   = $signed(22'(last.side.e2));
  assign a_in1 = (a_ext > sl) && (a_ext < su);
  assign b_in1 = (b_ext > sl) && (b_ext < su);
  assign a_in2 = (a_s > lo2) && (a_s < hi2);
  assign b_in2 = (b_s > lo2) && (b_s < hi2);
  assign fit   = (a_in1 && b_in2) || (b_in1 && a_in2);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= last.side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_is_candidate_r <= last.side.check && fit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_candidate = out_is_candidate_r;

  // checks
  `CPWC_ASSERT_NEXT(a_nocheck_zero, advance && last.side.valid && !last.side.check, !out_is_candidate)
  `CPWC_ASSERT_NEXT(a_stall_hold, !advance && last.side.valid, $stable(last))
  `CPWC_ASSERT_NOW(a_rem_below, last.side.valid, (last.lane_u.rem < last.lane_u.den) && (last.lane_l.rem < last.lane_l.den))

endmodule
